// ----- rtl/gtac_pkg.sv -----
// ----------------------------------------------------------------------------
// Gas and temperature alarm controller package
// Sizes, scale factors, register map and the tick flag bundle shared by the
// controller core.
// ----------------------------------------------------------------------------
package gtac_pkg;

  // Averaging ring and sample sizes
  localparam int AVG_SAMPLES = 100;
  localparam int ADC_BITS    = 12;
  localparam int CODE_KEYS   = 4;
  localparam int RING_AW     = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int SUM_W       = ADC_BITS + $clog2(AVG_SAMPLES + 1);

  // Threshold scaling: sum * 330 > celsius * 2^ADC_BITS * AVG_SAMPLES
  // (3.3 V full scale at 10 mV per degree)
  localparam int TEMP_W       = 9;
  localparam int VOLT_SCALE   = 330;
  localparam int LHS_W        = SUM_W + $clog2(VOLT_SCALE + 1);
  localparam int RHS_W        = TEMP_W + ADC_BITS + $clog2(AVG_SAMPLES + 1);
  localparam int CMP_W        = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int THRESH_SCALE = (1 << ADC_BITS) * AVG_SAMPLES;

  // Blink counter and attempt counter
  localparam int BLINK_W   = 10;
  localparam int BLINK_MAX = (1 << BLINK_W) - 1;
  localparam int ATTEMPT_W = 4;

  // Register reset values
  localparam int RST_OVER_TEMP  = 50;
  localparam int RST_UNLOCK     = 12;
  localparam int RST_BLINK_GAS  = 100;
  localparam int RST_BLINK_TEMP = 50;
  localparam int RST_BLINK_BOTH = 10;
  localparam int RST_MAX_ATT    = 5;

  // APB register map (word index)
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OVER_TEMP  = 3'd0,
    REG_UNLOCK     = 3'd1,
    REG_BLINK_GAS  = 3'd2,
    REG_BLINK_TEMP = 3'd3,
    REG_BLINK_BOTH = 3'd4,
    REG_MAX_ATT    = 3'd5
  } reg_idx_e;

  // Per-tick control inputs carried down the pipeline
  typedef struct packed {
    logic                 gas_now;
    logic                 test;
    logic                 enter;
    logic [CODE_KEYS-1:0] keys;
  } tick_t;

endpackage

// ----- rtl/gas_temp_alarm_controller_core.sv -----
// ----------------------------------------------------------------------------
// Gas and temperature alarm controller core
// Averages the temperature over a ring of samples held in a RAM, latches the
// alarm on gas, over-temperature or test, blinks the LED and checks codes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  tick    | in        | in_valid_i / in_stall_o | temp_sample_i, gas_line_n_i,
//          |           |                        | test_button_i, enter_button_i,
//          |           |                        | key_pattern_i
//  result  | out       | out_valid_o/out_stall_i | alarm_active_o, alarm_led_o,
//          |           |                        | siren_on_o, wrong_code_led_o,
//          |           |                        | locked_led_o, over_temp_o
//  config  | in        | APB (psel/penable)     | paddr, pwdata, prdata
//
// One tick per cycle is taken while in_stall_o is low; an accepted tick passes
// through the stage 1, stage 2 and stage 3 registers into the output register.
// Stages: ring RAM read, running-sum update and RAM write-back, threshold
// multiply and compare, alarm control into the output register.
// Reset clears the ring through one valid flip-flop per entry; no clearing pass.
// A stalled output holds every stage behind it that has no free slot.
//
module gas_temp_alarm_controller_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tick channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [gtac_pkg::ADC_BITS-1:0]      temp_sample_i,
  input  logic                               gas_line_n_i,
  input  logic                               test_button_i,
  input  logic                               enter_button_i,
  input  logic [gtac_pkg::CODE_KEYS-1:0]     key_pattern_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               alarm_active_o,
  output logic                               alarm_led_o,
  output logic                               siren_on_o,
  output logic                               wrong_code_led_o,
  output logic                               locked_led_o,
  output logic                               over_temp_o,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gtac_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int AW = gtac_pkg::RING_AW;
  localparam int SW = gtac_pkg::SUM_W;
  localparam int CW = gtac_pkg::CMP_W;
  localparam int BW = gtac_pkg::BLINK_W;
  localparam int NW = gtac_pkg::ATTEMPT_W;
  localparam int DW = gtac_pkg::ADC_BITS;
  localparam int KW = gtac_pkg::CODE_KEYS;
  localparam int TW = gtac_pkg::TEMP_W;
  localparam logic [AW-1:0] LAST_POS = AW'(gtac_pkg::AVG_SAMPLES - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TW-1:0] over_temp_q;
  logic [CW-1:0] thresh_q, thresh_d;
  logic [3:0]    unlock_q;
  logic [BW-1:0] blink_gas_q, blink_temp_q, blink_both_q;
  logic [3:0]    max_att_q;
  logic          cfg_wr;
  gtac_pkg::reg_idx_e cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_idx  = gtac_pkg::reg_idx_e'(paddr[gtac_pkg::PADDR_W-1:2]);
  // Scale the threshold once on write so the tick path only multiplies the sum
  assign thresh_d = CW'(pwdata[TW-1:0]) * CW'(gtac_pkg::THRESH_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      over_temp_q  <= TW'(gtac_pkg::RST_OVER_TEMP);
      thresh_q     <= CW'(gtac_pkg::RST_OVER_TEMP) * CW'(gtac_pkg::THRESH_SCALE);
      unlock_q     <= 4'(gtac_pkg::RST_UNLOCK);
      blink_gas_q  <= BW'(gtac_pkg::RST_BLINK_GAS);
      blink_temp_q <= BW'(gtac_pkg::RST_BLINK_TEMP);
      blink_both_q <= BW'(gtac_pkg::RST_BLINK_BOTH);
      max_att_q    <= 4'(gtac_pkg::RST_MAX_ATT);
    end else if (cfg_wr) begin
      case (cfg_idx)
        gtac_pkg::REG_OVER_TEMP: begin
          over_temp_q <= pwdata[TW-1:0];
          thresh_q    <= thresh_d;
        end
        gtac_pkg::REG_UNLOCK:     unlock_q     <= pwdata[3:0];
        gtac_pkg::REG_BLINK_GAS:  blink_gas_q  <= pwdata[BW-1:0];
        gtac_pkg::REG_BLINK_TEMP: blink_temp_q <= pwdata[BW-1:0];
        gtac_pkg::REG_BLINK_BOTH: blink_both_q <= pwdata[BW-1:0];
        gtac_pkg::REG_MAX_ATT:    max_att_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      gtac_pkg::REG_OVER_TEMP:  prdata = 32'(over_temp_q);
      gtac_pkg::REG_UNLOCK:     prdata = 32'(unlock_q);
      gtac_pkg::REG_BLINK_GAS:  prdata = 32'(blink_gas_q);
      gtac_pkg::REG_BLINK_TEMP: prdata = 32'(blink_temp_q);
      gtac_pkg::REG_BLINK_BOTH: prdata = 32'(blink_both_q);
      gtac_pkg::REG_MAX_ATT:    prdata = 32'(max_att_q);
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic in_fire, s1_adv, s2_adv, s3_adv;

  assign out_free = ~out_vld_q | ~out_stall_i;
  assign s3_free  = ~s3_vld_q  | out_free;
  assign s2_free  = ~s2_vld_q  | s3_free;
  assign s1_free  = ~s1_vld_q  | s2_free;
  assign in_stall_o = ~s1_free;
  assign in_fire  = in_valid_i & s1_free;
  assign s1_adv   = s1_vld_q & s2_free;
  assign s2_adv   = s2_vld_q & s3_free;
  assign s3_adv   = s3_vld_q & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free) s1_vld_q  <= in_fire;
      if (s2_free) s2_vld_q  <= s1_adv;
      if (s3_free) s3_vld_q  <= s2_adv;
      if (out_free) out_vld_q <= s3_adv;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: read the ring entry being replaced
  // --------------------------------------------------------------------------
  logic [DW-1:0] ring_mem [gtac_pkg::AVG_SAMPLES];
  logic [gtac_pkg::AVG_SAMPLES-1:0] ring_vld_q;
  logic [AW-1:0] pos_q;
  logic [DW-1:0] rd_q, s1_sample_q, fwd_data_q;
  logic          rdv_q, fwd_q;
  logic [AW-1:0] s1_pos_q;
  gtac_pkg::tick_t s1_tick_q, in_tick;

  assign in_tick.gas_now = ~gas_line_n_i;
  assign in_tick.test    = test_button_i;
  assign in_tick.enter   = enter_button_i;
  assign in_tick.keys    = key_pattern_i;

  // Advance the write position on every accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + AW'(1);
    end
  end

  // Synchronous RAM read, plus forward of a write to the same entry
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q        <= ring_mem[pos_q];
      s1_sample_q <= temp_sample_i;
      s1_tick_q   <= in_tick;
      s1_pos_q    <= pos_q;
      fwd_q       <= s1_adv && (s1_pos_q == pos_q);
      fwd_data_q  <= s1_sample_q;
    end
  end

  // Entry valid flags: an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q      <= 1'b0;
      ring_vld_q <= '0;
    end else begin
      if (in_fire) rdv_q <= ring_vld_q[pos_q];
      if (s1_adv)  ring_vld_q[s1_pos_q] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: running sum update and ring write-back
  // --------------------------------------------------------------------------
  logic [SW-1:0] sum_q, sum_d, s2_sum_q;
  logic [DW-1:0] old_sample;
  gtac_pkg::tick_t s2_tick_q;

  always_comb begin
    if (fwd_q) begin
      old_sample = fwd_data_q;
    end else if (rdv_q) begin
      old_sample = rd_q;
    end else begin
      old_sample = '0;
    end
    sum_d = sum_q - SW'(old_sample) + SW'(s1_sample_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_adv) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ring_mem[s1_pos_q] <= s1_sample_q;
      s2_sum_q           <= sum_d;
      s2_tick_q          <= s1_tick_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: over-temperature compare
  // --------------------------------------------------------------------------
  logic [CW-1:0] lhs;
  logic          s3_over_q;
  gtac_pkg::tick_t s3_tick_q;

  assign lhs = CW'(s2_sum_q) * CW'(gtac_pkg::VOLT_SCALE);

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_over_q <= lhs > thresh_q;
      s3_tick_q <= s2_tick_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: alarm latches, blink and code check
  // --------------------------------------------------------------------------
  logic          alarm_q, alarm_d, gas_q, gas_d, heat_q, heat_d;
  logic          led_q, led_d, err_q, err_d, lock_q, lock_d;
  logic [BW-1:0] blink_q, blink_d, period;
  logic [NW-1:0] att_q, att_d;
  logic          siren_d, siren_q, over_q, have_period, key_match;

  assign key_match = (s3_tick_q.keys[KW-1:0] == unlock_q[KW-1:0]);

  always_comb begin
    alarm_d     = alarm_q;
    gas_d       = gas_q;
    heat_d      = heat_q;
    blink_d     = blink_q;
    led_d       = led_q;
    err_d       = err_q;
    att_d       = att_q;
    lock_d      = lock_q;
    period      = '0;
    have_period = 1'b1;

    // Latch the causes
    if (s3_tick_q.gas_now) begin
      gas_d   = 1'b1;
      alarm_d = 1'b1;
    end
    if (s3_over_q) begin
      heat_d  = 1'b1;
      alarm_d = 1'b1;
    end
    if (s3_tick_q.test) begin
      gas_d   = 1'b1;
      heat_d  = 1'b1;
      alarm_d = 1'b1;
    end

    // Blink while latched, otherwise drop the LED and causes
    siren_d = alarm_d;
    if (alarm_d) begin
      if (blink_q != BW'(gtac_pkg::BLINK_MAX)) blink_d = blink_q + BW'(1);
      if (gas_d && heat_d) begin
        period = blink_both_q;
      end else if (gas_d) begin
        period = blink_gas_q;
      end else if (heat_d) begin
        period = blink_temp_q;
      end else begin
        have_period = 1'b0;
      end
      if (have_period && (blink_d >= period)) begin
        blink_d = '0;
        led_d   = ~led_q;
      end
    end else begin
      led_d  = 1'b0;
      gas_d  = 1'b0;
      heat_d = 1'b0;
    end

    // Code check unless locked out
    if (att_q < NW'(max_att_q)) begin
      if (key_match && !s3_tick_q.enter) err_d = 1'b0;
      if (s3_tick_q.enter && !err_d && alarm_d) begin
        if (key_match) begin
          alarm_d = 1'b0;
          att_d   = '0;
        end else begin
          err_d = 1'b1;
          att_d = att_q + NW'(1);
        end
      end
    end else begin
      lock_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= 1'b0;
      gas_q   <= 1'b0;
      heat_q  <= 1'b0;
      blink_q <= '0;
      led_q   <= 1'b0;
      err_q   <= 1'b0;
      att_q   <= '0;
      lock_q  <= 1'b0;
    end else if (s3_adv) begin
      alarm_q <= alarm_d;
      gas_q   <= gas_d;
      heat_q  <= heat_d;
      blink_q <= blink_d;
      led_q   <= led_d;
      err_q   <= err_d;
      att_q   <= att_d;
      lock_q  <= lock_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      siren_q <= siren_d;
      over_q  <= s3_over_q;
    end
  end

  // State flags change only when a new result loads, so they double as payload
  assign out_valid_o      = out_vld_q;
  assign alarm_active_o   = alarm_q;
  assign alarm_led_o      = led_q;
  assign siren_on_o       = siren_q;
  assign wrong_code_led_o = err_q;
  assign locked_led_o     = lock_q;
  assign over_temp_o      = over_q;

endmodule
